@@ design/torg_pkg.sv @@
// Shared constants, register indexes and types for the tip-over recovery guard.
`default_nettype none

package torg_pkg;

    // Stream widths: tdata packed from bit 0, padded to whole bytes
    localparam int S_PAYLOAD_W = 109;
    localparam int S_TDATA_W   = 112;
    localparam int M_PAYLOAD_W = 21;
    localparam int M_TDATA_W   = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_BANK_TRIP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_TRIP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_PITCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_BOOST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_THR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DEADBAND = 3'd7;

    // Register reset values
    localparam logic [7:0]        RST_BANK_TRIP      = 8'd60;
    localparam logic [10:0]       RST_SINK_TRIP      = 11'd100;
    localparam logic signed [7:0] RST_RECOVERY_PITCH = 8'sd0;
    localparam logic [6:0]        RST_THROTTLE_BOOST = 7'd30;
    localparam logic [7:0]        RST_MIN_HEIGHT     = 8'd10;
    localparam logic [10:0]       RST_CRUISE_THR     = 11'd1400;
    localparam logic [10:0]       RST_MAX_THR        = 11'd2000;
    localparam logic [6:0]        RST_STICK_DEADBAND = 7'd5;

    // Timing windows in milliseconds
    localparam int TRIP_MS       = 300;
    localparam int MIN_HOLD_MS   = 5000;
    localparam int BURST_MS      = 2000;
    localparam int LEVEL_HOLD_MS = 1500;

    // Bank thresholds in tenths of a degree
    localparam logic [11:0] RELEASE_BANK_DECIDEG = 12'd200;
    localparam logic [11:0] PITCH_BANK_DECIDEG   = 12'd300;
    localparam logic [11:0] DEG_TO_DECIDEG       = 12'd10;
    localparam logic [14:0] M_TO_CM              = 15'd100;

    // Throttle floor arithmetic
    localparam logic signed [11:0] THROTTLE_BASE_US = 12'sd1000;
    localparam logic signed [13:0] FLOOR_MAX_US     = 14'sd4095;
    // x / 100 == (x * 167773) >> 24, exact for x below 199728
    localparam logic [17:0]        DIV100_RECIP     = 18'd167773;
    localparam int                 DIV100_SHIFT     = 24;

    // Control bundle into the throttle floor unit
    typedef struct packed {
        logic active;
        logic height_ok;
        logic in_burst;
    } floor_ctrl_t;

endpackage

`default_nettype wire

@@ design/torg_floor.sv @@
// Throttle floor unit: burst level or boosted baseline, clamped, with height gate.
`default_nettype none

module torg_floor
    import torg_pkg::*;
(
    input  floor_ctrl_t ctrl,
    input  logic [10:0] baseline_us,
    input  logic [17:0] boost_mag,
    input  logic        boost_neg,
    input  logic [10:0] max_throttle_us,
    output logic [11:0] floor_us
);

    logic [35:0]        recip_prod;
    logic [11:0]        quot;
    logic signed [13:0] sum;
    logic [11:0]        clamped;

    // Magnitude divided by 100 through the reciprocal, truncation towards zero
    assign recip_prod = boost_mag * DIV100_RECIP;
    assign quot       = recip_prod[DIV100_SHIFT +: 12];

    // Baseline plus signed boost, clamped to the 12-bit range
    always_comb begin
        if (boost_neg) begin
            sum = $signed({3'b000, baseline_us}) - $signed({2'b00, quot});
        end else begin
            sum = $signed({3'b000, baseline_us}) + $signed({2'b00, quot});
        end
        if (sum < 14'sd0) begin
            clamped = 12'd0;
        end else if (sum > FLOOR_MAX_US) begin
            clamped = FLOOR_MAX_US[11:0];
        end else begin
            clamped = sum[11:0];
        end
    end

    // Output selection
    always_comb begin
        if (!(ctrl.active && ctrl.height_ok)) begin
            floor_us = 12'd0;
        end else if (ctrl.in_burst) begin
            floor_us = {1'b0, max_throttle_us};
        end else begin
            floor_us = clamped;
        end
    end

endmodule

`default_nettype wire

@@ design/tip_over_recovery_guard.sv @@
// Top level of the tip-over recovery guard: input stage, state update, result register.
`default_nettype none

// Takes one flight-loop tick per transaction and returns one result per tick. A new
// transaction is accepted every clock cycle unless a stall on m_tready holds the output.
// Each tick passes through the input register, then one update pass into the result
// register. Stalls on m_tready hold the input stage without losing the next tick. The
// per-tick state update and the throttle floor are computed in that single pass; the
// boost product is registered beside the state so the divide by 100 starts from a
// register. Configuration registers take effect for ticks accepted after the write.
// time_ms is truncated to TIME_BITS bits and all windows wrap modulo 2^TIME_BITS.
module tip_over_recovery_guard
    import torg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] guard_enabled, [1] throttle_idle, [13:2] roll_decideg, [27:14] climb_rate_cms,
    // [45:28] height_cm, [56:46] throttle_cmd_us, [66:57] stick_roll,
    // [76:67] stick_pitch, [108:77] time_ms, [111:109] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] recovery_active, [12:1] throttle_floor_us, [20:13] pitch_target_deg,
    // [23:21] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // Configuration registers
    logic [7:0]        bank_trip_reg;
    logic [10:0]       sink_trip_reg;
    logic signed [7:0] rec_pitch_reg;
    logic [6:0]        boost_pct_reg;
    logic [7:0]        min_height_reg;
    logic [10:0]       cruise_thr_reg;
    logic [10:0]       max_thr_reg;
    logic [6:0]        deadband_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_trip_reg  <= RST_BANK_TRIP;
            sink_trip_reg  <= RST_SINK_TRIP;
            rec_pitch_reg  <= RST_RECOVERY_PITCH;
            boost_pct_reg  <= RST_THROTTLE_BOOST;
            min_height_reg <= RST_MIN_HEIGHT;
            cruise_thr_reg <= RST_CRUISE_THR;
            max_thr_reg    <= RST_MAX_THR;
            deadband_reg   <= RST_STICK_DEADBAND;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BANK_TRIP:      bank_trip_reg  <= cfg_wdata[7:0];
                CFG_SINK_TRIP:      sink_trip_reg  <= cfg_wdata;
                CFG_RECOVERY_PITCH: rec_pitch_reg  <= $signed(cfg_wdata[7:0]);
                CFG_THROTTLE_BOOST: boost_pct_reg  <= cfg_wdata[6:0];
                CFG_MIN_HEIGHT:     min_height_reg <= cfg_wdata[7:0];
                CFG_CRUISE_THR:     cruise_thr_reg <= cfg_wdata;
                CFG_MAX_THR:        max_thr_reg    <= cfg_wdata;
                CFG_STICK_DEADBAND: deadband_reg   <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Input stage and handshake
    logic                   in_valid_reg;
    logic [S_PAYLOAD_W-1:0] in_data_reg;
    logic                   out_free;
    logic                   advance;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[S_PAYLOAD_W-1:0];
        end
    end

    // Field unpacking
    logic                 guard_enabled;
    logic                 throttle_idle;
    logic signed [11:0]   roll_decideg;
    logic signed [13:0]   climb_rate_cms;
    logic signed [17:0]   height_cm;
    logic [10:0]          throttle_cmd_us;
    logic signed [9:0]    stick_roll;
    logic signed [9:0]    stick_pitch;
    logic [31:0]          time_ms;
    logic [63:0]          time_ext;
    logic [TIME_BITS-1:0] now;

    assign guard_enabled   = in_data_reg[0];
    assign throttle_idle   = in_data_reg[1];
    assign roll_decideg    = $signed(in_data_reg[13:2]);
    assign climb_rate_cms  = $signed(in_data_reg[27:14]);
    assign height_cm       = $signed(in_data_reg[45:28]);
    assign throttle_cmd_us = in_data_reg[56:46];
    assign stick_roll      = $signed(in_data_reg[66:57]);
    assign stick_pitch     = $signed(in_data_reg[76:67]);
    assign time_ms         = in_data_reg[108:77];
    assign time_ext        = {32'd0, time_ms};
    assign now             = time_ext[TIME_BITS-1:0];

    // Guard state
    logic                 in_rec_reg,       in_rec_next;
    logic                 trip_timing_reg,  trip_timing_next;
    logic [TIME_BITS-1:0] trip_start_reg,   trip_start_next;
    logic [TIME_BITS-1:0] rec_start_reg,    rec_start_next;
    logic                 level_timing_reg, level_timing_next;
    logic [TIME_BITS-1:0] level_start_reg,  level_start_next;
    logic                 centred_reg,      centred_next;
    logic [10:0]          baseline_reg,     baseline_next;

    // Comparisons on this tick's attitude, rates and sticks
    logic [11:0]          bank;
    logic [11:0]          trip_limit;
    logic signed [14:0]   sink_limit;
    logic                 tripping;
    logic [9:0]           sroll_abs;
    logic [9:0]           spitch_abs;
    logic                 deflected;
    logic [14:0]          min_height_cm;
    logic                 height_ok;
    logic [TIME_BITS-1:0] el_trip;
    logic [TIME_BITS-1:0] el_rec;
    logic [TIME_BITS-1:0] el_level;
    logic [TIME_BITS-1:0] el_burst;

    assign bank          = roll_decideg[11] ? (~roll_decideg + 12'd1) : roll_decideg;
    assign trip_limit    = 12'(bank_trip_reg) * DEG_TO_DECIDEG;
    assign sink_limit    = -$signed({4'b0000, sink_trip_reg});
    assign tripping      = (bank > trip_limit)
                        && ($signed({climb_rate_cms[13], climb_rate_cms}) < sink_limit);
    assign sroll_abs     = stick_roll[9]  ? (~stick_roll  + 10'd1) : stick_roll;
    assign spitch_abs    = stick_pitch[9] ? (~stick_pitch + 10'd1) : stick_pitch;
    assign deflected     = (sroll_abs > {3'b000, deadband_reg})
                        || (spitch_abs > {3'b000, deadband_reg});
    assign min_height_cm = 15'(min_height_reg) * M_TO_CM;
    assign height_ok     = $signed({height_cm[17], height_cm})
                        >= $signed({4'b0000, min_height_cm});
    assign el_trip       = now - trip_start_reg;
    assign el_rec        = now - rec_start_reg;
    assign el_level      = now - level_start_reg;
    assign el_burst      = now - rec_start_next;

    // State update for one tick
    always_comb begin
        in_rec_next       = in_rec_reg;
        trip_timing_next  = trip_timing_reg;
        trip_start_next   = trip_start_reg;
        rec_start_next    = rec_start_reg;
        level_timing_next = level_timing_reg;
        level_start_next  = level_start_reg;
        centred_next      = centred_reg;
        baseline_next     = baseline_reg;
        if (!guard_enabled || throttle_idle) begin
            in_rec_next      = 1'b0;
            trip_timing_next = 1'b0;
        end else if (!in_rec_reg) begin
            // Watching for a tip-over
            if (tripping) begin
                if (!trip_timing_reg) begin
                    trip_timing_next = 1'b1;
                    trip_start_next  = now;
                end else if (el_trip > TIME_BITS'(TRIP_MS)) begin
                    in_rec_next       = 1'b1;
                    rec_start_next    = now;
                    level_timing_next = 1'b0;
                    centred_next      = 1'b0;
                    baseline_next     = (throttle_cmd_us > cruise_thr_reg) ?
                                        throttle_cmd_us : cruise_thr_reg;
                end
            end else begin
                trip_timing_next = 1'b0;
            end
        end else begin
            // Recovering: level-hold release
            if ((el_rec > TIME_BITS'(MIN_HOLD_MS)) && (bank < RELEASE_BANK_DECIDEG)) begin
                if (!level_timing_reg) begin
                    level_timing_next = 1'b1;
                    level_start_next  = now;
                end else if (el_level > TIME_BITS'(LEVEL_HOLD_MS)) begin
                    in_rec_next       = 1'b0;
                    trip_timing_next  = 1'b0;
                    level_timing_next = 1'b0;
                end
            end else begin
                level_timing_next = 1'b0;
            end
            // Pilot takeover once the sticks have been centred
            if (!centred_reg) begin
                centred_next = !deflected;
            end else if (deflected) begin
                in_rec_next      = 1'b0;
                trip_timing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rec_reg       <= 1'b0;
            trip_timing_reg  <= 1'b0;
            trip_start_reg   <= '0;
            rec_start_reg    <= '0;
            level_timing_reg <= 1'b0;
            level_start_reg  <= '0;
            centred_reg      <= 1'b0;
            baseline_reg     <= 11'd0;
        end else if (advance) begin
            in_rec_reg       <= in_rec_next;
            trip_timing_reg  <= trip_timing_next;
            trip_start_reg   <= trip_start_next;
            rec_start_reg    <= rec_start_next;
            level_timing_reg <= level_timing_next;
            level_start_reg  <= level_start_next;
            centred_reg      <= centred_next;
            baseline_reg     <= baseline_next;
        end
    end

    // Boost product (baseline - 1000) * percent, kept as sign and magnitude
    logic [10:0]        baseline_commit;
    logic signed [11:0] boost_diff;
    logic [10:0]        boost_diff_mag;
    logic [17:0]        boost_mag_reg;
    logic               boost_neg_reg;

    assign baseline_commit = advance ? baseline_next : baseline_reg;
    assign boost_diff      = $signed({1'b0, baseline_commit}) - THROTTLE_BASE_US;
    assign boost_diff_mag  = boost_diff[11] ? 11'(-boost_diff) : boost_diff[10:0];

    always_ff @(posedge aclk) begin
        boost_mag_reg <= 18'(boost_diff_mag) * 18'(boost_pct_reg);
        boost_neg_reg <= boost_diff[11];
    end

    // Throttle floor for this tick
    floor_ctrl_t floor_ctrl;
    logic [11:0] floor_us;

    // active, height_ok, in_burst from the top bit down
    assign floor_ctrl = {in_rec_next, height_ok, (el_burst < TIME_BITS'(BURST_MS))};

    torg_floor u_floor (
        .ctrl            (floor_ctrl),
        .baseline_us     (baseline_next),
        .boost_mag       (boost_mag_reg),
        .boost_neg       (boost_neg_reg),
        .max_throttle_us (max_thr_reg),
        .floor_us        (floor_us)
    );

    // Pitch target while bank is steep
    logic signed [7:0] pitch_target;

    assign pitch_target = (bank > PITCH_BANK_DECIDEG) ? rec_pitch_reg : 8'sd0;

    // Result register
    logic                   out_valid_reg;
    logic [M_PAYLOAD_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {pitch_target, floor_us, in_rec_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_PAYLOAD_W){1'b0}}, out_data_reg};

    // Assertions
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(in_rec_reg) && $stable(baseline_reg) && $stable(centred_reg))
        else $error("guard state changed without a transaction being processed");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("stalled input stage lost or changed its transaction");

    a_trip_resets_release: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_rec_reg && in_rec_next |=> in_rec_reg && !level_timing_reg
        && !centred_reg && (baseline_reg >= cruise_thr_reg))
        else $error("trip did not start a clean recovery");

    a_floor_needs_recovery: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_data_reg[12:1] != 12'd0) |-> out_data_reg[0])
        else $error("throttle floor claimed outside recovery");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for the tip-over recovery guard: scripted flights, noise and checks.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import torg_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;

    // One flight-loop tick as driven on the input stream
    typedef struct {
        bit                 en;
        bit                 idle;
        logic signed [11:0] roll;
        logic signed [13:0] climb;
        logic signed [17:0] height;
        logic [10:0]        thr;
        logic signed [9:0]  sroll;
        logic signed [9:0]  spitch;
        logic [31:0]        tms;
    } tick_t;

    // One guard result
    typedef struct {
        bit                active;
        logic [11:0]       floor_us;
        logic signed [7:0] pitch;
    } guard_res_t;

    // Register set, plain integers in engineering units
    typedef struct {
        int bank;
        int sink;
        int pitch;
        int boost;
        int minh;
        int cruise;
        int maxthr;
        int db;
    } guard_cfg_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    tip_over_recovery_guard i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Predicted guard state and register copy
    guard_cfg_t  cfg_now;
    bit          p_in_rec, p_trip_timing, p_level_timing, p_centred;
    logic [31:0] p_trip_start, p_rec_start, p_level_start;
    int          p_baseline;

    guard_res_t  expected_results[$];
    logic [31:0] flight_ms = 32'd20000;

    int errors          = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int settings_used   = 1;
    int trips_entered   = 0;
    int ends_level      = 0;
    int ends_stick      = 0;
    int ends_disarm     = 0;
    int send_idle_pct   = 0;
    int rcv_stall_pct   = 0;
    int hold_req        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int cycles          = 0;

    // ---------------------------------------------------------------- prediction

    function automatic void guard_reset();
        cfg_now        = '{60, 100, 0, 30, 10, 1400, 2000, 5};
        p_in_rec       = 1'b0;
        p_trip_timing  = 1'b0;
        p_level_timing = 1'b0;
        p_centred      = 1'b0;
        p_trip_start   = '0;
        p_rec_start    = '0;
        p_level_start  = '0;
        p_baseline     = 0;
    endfunction

    // State update for one tick, then the result from the updated state
    function automatic guard_res_t guard_update(tick_t t);
        guard_res_t  r;
        int          bank, sr, sp, floor_us;
        bit          deflected;
        logic [31:0] now;
        now      = t.tms;
        bank     = (t.roll < 0) ? -int'(t.roll) : int'(t.roll);
        sr       = (t.sroll < 0) ? -int'(t.sroll) : int'(t.sroll);
        sp       = (t.spitch < 0) ? -int'(t.spitch) : int'(t.spitch);
        floor_us = 0;

        if (!t.en || t.idle) begin
            if (p_in_rec) ends_disarm++;
            p_in_rec      = 1'b0;
            p_trip_timing = 1'b0;
        end else if (!p_in_rec) begin
            // trip detection: steep bank while sinking, held past the trip window
            if (bank > cfg_now.bank * 10 && int'(t.climb) < -cfg_now.sink) begin
                if (!p_trip_timing) begin
                    p_trip_timing = 1'b1;
                    p_trip_start  = now;
                end else if (now - p_trip_start > TRIP_MS) begin
                    p_in_rec       = 1'b1;
                    p_rec_start    = now;
                    p_level_timing = 1'b0;
                    p_centred      = 1'b0;
                    p_baseline     = (int'(t.thr) > cfg_now.cruise) ? int'(t.thr)
                                                                    : cfg_now.cruise;
                    trips_entered++;
                end
            end else begin
                p_trip_timing = 1'b0;
            end
        end else begin
            // release on sustained level flight after the minimum hold
            if (now - p_rec_start > MIN_HOLD_MS && bank < 200) begin
                if (!p_level_timing) begin
                    p_level_timing = 1'b1;
                    p_level_start  = now;
                end else if (now - p_level_start > LEVEL_HOLD_MS) begin
                    p_in_rec       = 1'b0;
                    p_trip_timing  = 1'b0;
                    p_level_timing = 1'b0;
                    ends_level++;
                end
            end else begin
                p_level_timing = 1'b0;
            end
            // release on fresh stick input once centred
            deflected = (sr > cfg_now.db) || (sp > cfg_now.db);
            if (!p_centred) begin
                p_centred = !deflected;
            end else if (deflected) begin
                if (p_in_rec) ends_stick++;
                p_in_rec      = 1'b0;
                p_trip_timing = 1'b0;
            end
        end

        // throttle floor
        if (p_in_rec && int'(t.height) >= cfg_now.minh * 100) begin
            if (now - p_rec_start < BURST_MS) begin
                floor_us = cfg_now.maxthr;
            end else begin
                floor_us = p_baseline + (p_baseline - 1000) * cfg_now.boost / 100;
                if (floor_us < 0) floor_us = 0;
                if (floor_us > 4095) floor_us = 4095;
            end
        end

        r.active   = p_in_rec;
        r.floor_us = 12'(floor_us);
        r.pitch    = (bank > 300) ? 8'(cfg_now.pitch) : 8'sd0;
        return r;
    endfunction

    // ---------------------------------------------------------------- result checking

    always @(posedge aclk) begin
        guard_res_t        want;
        logic [11:0]       got_floor;
        logic signed [7:0] got_pitch;
        if (aresetn && m_tvalid && m_tready) begin
            got_floor = m_tdata[12:1];
            got_pitch = m_tdata[20:13];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, tdata %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_tdata[0] !== want.active) begin
                    $display("%0t: recovery_active expected %0d got %0d",
                             $time, want.active, m_tdata[0]);
                    errors++;
                end
                if (got_floor !== want.floor_us) begin
                    $display("%0t: throttle_floor_us expected %0d got %0d",
                             $time, want.floor_us, got_floor);
                    errors++;
                end
                if (got_pitch !== want.pitch) begin
                    $display("%0t: pitch_target_deg expected %0d got %0d",
                             $time, want.pitch, got_pitch);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driving

    // Offer one tick, with random gaps ahead of it; predict on acceptance
    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t.tms, t.spitch, t.sroll, t.thr, t.height, t.climb,
                     t.roll, t.idle, t.en};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(guard_update(t));
        ticks_sent++;
    endtask

    task automatic send_fields(input bit en, input bit idle, input int roll, input int climb,
                               input int height, input int thr, input int sr, input int sp,
                               input logic [31:0] tms);
        tick_t t;
        t.en     = en;
        t.idle   = idle;
        t.roll   = 12'(roll);
        t.climb  = 14'(climb);
        t.height = 18'(height);
        t.thr    = 11'(thr);
        t.sroll  = 10'(sr);
        t.spitch = 10'(sp);
        t.tms    = tms;
        send_tick(t);
    endtask

    // Stop offering and wait until every result is back and the pipe is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v[CFG_DATA_W-1:0];
        @(posedge aclk);
    endtask

    // Only called with the block idle
    task automatic apply_config(input guard_cfg_t c);
        cfg_now = c;
        write_reg(CFG_BANK_TRIP, c.bank);
        write_reg(CFG_SINK_TRIP, c.sink);
        write_reg(CFG_RECOVERY_PITCH, c.pitch & 'hFF);
        write_reg(CFG_THROTTLE_BOOST, c.boost);
        write_reg(CFG_MIN_HEIGHT, c.minh);
        write_reg(CFG_CRUISE_THR, c.cruise);
        write_reg(CFG_MAX_THR, c.maxthr);
        write_reg(CFG_STICK_DEADBAND, c.db);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    task automatic set_idle(input int send_pct, input int rcv_pct);
        send_idle_pct = send_pct;
        rcv_stall_pct = rcv_pct;
    endtask

    // ---------------------------------------------------------------- tick generation

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int rand_sign(int mag);
        return $urandom_range(1) ? mag : -mag;
    endfunction

    function automatic int centred_stick();
        return rand_between(-cfg_now.db, cfg_now.db);
    endfunction

    function automatic int deflected_stick();
        return rand_sign(rand_between(cfg_now.db + 1, 500));
    endfunction

    // Mostly close to the height gate, sometimes anywhere
    function automatic int gate_height();
        if ($urandom_range(99) < 85)
            return cfg_now.minh * 100 + rand_between(-1500, 1500);
        return rand_between(-100000, 100000);
    endfunction

    function automatic int steep_roll();
        int lo;
        lo = cfg_now.bank * 10 + 1;
        if (lo > 1800) lo = 1800;
        return rand_sign(rand_between(lo, 1800));
    endfunction

    // Level flight, with the release and pitch thresholds hit now and then
    function automatic int level_roll();
        case ($urandom_range(11))
            0: return 199;
            1: return -200;
            2: return 300;
            3: return -301;
            default: return rand_between(-199, 199);
        endcase
    endfunction

    function automatic tick_t base_tick();
        tick_t t;
        t.en     = 1'b1;
        t.idle   = 1'b0;
        t.roll   = 12'(rand_between(-150, 150));
        t.climb  = 14'(rand_between(-5000, 5000));
        t.height = 18'(gate_height());
        t.thr    = 11'(rand_between(1000, 2000));
        t.sroll  = 10'(centred_stick());
        t.spitch = 10'(centred_stick());
        t.tms    = flight_ms;
        return t;
    endfunction

    function automatic tick_t noise_tick();
        tick_t t;
        if ($urandom_range(4) == 0) flight_ms = $urandom();
        else                        flight_ms += rand_between(1, 500);
        t.en     = 1'($urandom_range(1));
        t.idle   = 1'($urandom_range(1));
        t.roll   = 12'(rand_between(-1800, 1800));
        t.climb  = 14'(rand_between(-5000, 5000));
        t.height = 18'(rand_between(-100000, 100000));
        t.thr    = 11'(rand_between(1000, 2000));
        t.sroll  = 10'(rand_between(-500, 500));
        t.spitch = 10'(rand_between(-500, 500));
        t.tms    = flight_ms;
        return t;
    endfunction

    // A full tip-over: level flight, steep sinking bank, then a recovery with one ending
    task automatic fly_tipover();
        tick_t t;
        int    held, target, n, k, i, dt, ending;
        bit    timing;
        if ($urandom_range(9) == 0) flight_ms = 32'hFFFF_FFFF - $urandom_range(3000);
        n = rand_between(1, 4);
        for (i = 0; i < n; i++) begin
            flight_ms += rand_between(20, 200);
            send_tick(base_tick());
        end

        // steep bank while sinking; an odd broken tick restarts the window
        held   = 0;
        timing = 1'b0;
        target = TRIP_MS + rand_between(1, 200);
        for (i = 0; i < 30 && held <= target; i++) begin
            dt = rand_between(20, 150);
            flight_ms += dt;
            t = base_tick();
            if ($urandom_range(15) == 0) begin
                timing = 1'b0;
                held   = 0;
            end else begin
                t.roll  = 12'(steep_roll());
                t.climb = 14'(-rand_between(cfg_now.sink + 1, 5000));
                if (!timing) begin
                    timing = 1'b1;
                    held   = 0;
                end else begin
                    held += dt;
                end
            end
            send_tick(t);
        end

        // recovery: steep at first, then mostly level
        ending = $urandom_range(3);
        n = rand_between(10, 60);
        k = rand_between(2, n);
        for (i = 0; i < n; i++) begin
            flight_ms += rand_between(50, 350);
            t = base_tick();
            if (i < n / 4)
                t.roll = 12'(rand_sign(rand_between(200, 1800)));
            else if ($urandom_range(19) == 0)
                t.roll = 12'(rand_sign(rand_between(200, 400)));
            else
                t.roll = 12'(level_roll());
            // sticks still held over right after the trip
            if (i < 2 && $urandom_range(2) == 0) t.sroll = 10'(deflected_stick());
            if (ending == 2 && i >= k) begin
                if ($urandom_range(1)) t.sroll  = 10'(deflected_stick());
                else                   t.spitch = 10'(deflected_stick());
            end
            if (ending == 3 && i == k) begin
                if ($urandom_range(1)) t.en   = 1'b0;
                else                   t.idle = 1'b1;
            end
            send_tick(t);
            if (ending >= 2 && i >= k + 2) break;
        end
    endtask

    // Mix of well-formed tip-overs and noise bursts
    task automatic fly_random(input int items);
        int target, n, i;
        target = ticks_sent + items;
        while (ticks_sent < target) begin
            if ($urandom_range(3) != 0) begin
                fly_tipover();
            end else begin
                n = rand_between(1, 8);
                for (i = 0; i < n; i++) send_tick(noise_tick());
            end
        end
    endtask

    function automatic guard_cfg_t random_cfg();
        guard_cfg_t c;
        c.bank   = rand_between(0, 120);
        c.sink   = rand_between(0, 1500);
        c.pitch  = rand_between(-90, 90);
        c.boost  = rand_between(0, 100);
        c.minh   = rand_between(0, 255);
        c.cruise = rand_between(1000, 2000);
        c.maxthr = rand_between(1000, 2000);
        c.db     = rand_between(0, 100);
        return c;
    endfunction

    // ---------------------------------------------------------------- tests

    // Field extremes, trip across the time wrap, burst edge, height gate,
    // level release, stick release and disarm, all at reset register values
    task automatic test_directed();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        set_idle(0, 0);
        send_fields(0, 0, -1800, -5000, -100000, 1000, -500, -500, 32'd0);
        send_fields(1, 1, 1800, 5000, 100000, 2000, 500, 500, 32'hFFFF_FFFF);
        send_fields(1, 0, 0, 0, 0, 1500, 0, 0, 32'd100);
        send_fields(1, 0, -1800, -5000, 100000, 1000, 0, 0, t0);
        send_fields(1, 0, -1800, -5000, 100000, 1000, 0, 0, t0 + 300);
        send_fields(1, 0, -1800, -5000, 100000, 1000, 0, 0, t0 + 301);
        send_fields(1, 0, 1800, -5000, 100000, 1000, 0, 0, t0 + 2300);
        send_fields(1, 0, 301, 0, 1000, 1000, 0, 0, t0 + 2301);
        send_fields(1, 0, 300, 0, 999, 1000, 0, 0, t0 + 2400);
        send_fields(1, 0, 199, 0, 5000, 1000, 0, 0, t0 + 5302);
        send_fields(1, 0, -199, 0, 5000, 1000, 0, 0, t0 + 6802);
        send_fields(1, 0, 0, 0, 5000, 1000, 0, 0, t0 + 6803);
        send_fields(0, 0, 0, 0, 5000, 1000, 0, 0, t0 + 6900);
        send_fields(1, 0, -601, -101, 5000, 1900, 0, 0, 32'd10000);
        send_fields(1, 0, -601, -101, 5000, 1900, 0, 0, 32'd10301);
        send_fields(1, 0, 700, 0, 5000, 1900, 6, 0, 32'd10400);
        send_fields(1, 0, 700, 0, 5000, 1900, 5, -5, 32'd10500);
        send_fields(1, 0, 700, 0, 5000, 1900, 0, -6, 32'd10600);
        send_fields(1, 0, 600, -101, 5000, 1900, 0, 0, 32'd11000);
        send_fields(1, 0, 601, -100, 5000, 1900, 0, 0, 32'd11400);
        send_fields(1, 0, 1000, -3000, 5000, 1200, 0, 0, 32'd12000);
        send_fields(1, 0, 1000, -3000, 5000, 1200, 0, 0, 32'd12400);
        send_fields(1, 1, 1000, -3000, 5000, 1200, 0, 0, 32'd12500);
        flight_ms = 32'd20000;
        wait_drained();
    endtask

    // Random flights on reset register values, no idling
    task automatic test_default_flights();
        set_idle(0, 0);
        fly_random(200);
        wait_drained();
    endtask

    // Lowest and highest register settings, including a bank limit that never trips
    task automatic test_extreme_settings();
        apply_config('{0, 0, -90, 0, 0, 1000, 1000, 0});
        set_idle(83, 0);
        fly_random(150);
        wait_drained();
        apply_config('{179, 2000, 90, 100, 255, 2000, 2000, 100});
        set_idle(0, 83);
        fly_random(150);
        wait_drained();
        apply_config('{180, 2000, 90, 100, 255, 2000, 2000, 100});
        set_idle(9, 9);
        fly_random(60);
        wait_drained();
    endtask

    // Random register settings over every idling pattern; one pause mid-stream
    task automatic test_random_settings();
        int i;
        for (i = 0; i < 4; i++) begin
            apply_config(random_cfg());
            case (i)
                0: set_idle(9, 9);
                1: set_idle(0, 0);
                2: set_idle(83, 0);
                default: set_idle(0, 83);
            endcase
            fly_random(75);
            if (i == 1) wait_drained();
            fly_random(75);
            wait_drained();
        end
    endtask

    // Receiver holds off for a long stretch while ticks keep coming
    task automatic test_output_backpressure();
        set_idle(0, 0);
        hold_req <= hold_req + 1;
        fly_random(40);
        wait_drained();
    endtask

    initial begin
        guard_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_default_flights();
        test_extreme_settings();
        test_random_settings();
        test_output_backpressure();

        set_idle(0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d ticks over %0d register settings, %0d results checked",
                 ticks_sent, settings_used, results_checked);
        $display("summary: %0d recoveries; ended by level flight %0d, stick %0d, disarm %0d",
                 trips_entered, ends_level, ends_stick, ends_disarm);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
